FILE: src/bfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfc_pkg: shared types and constants for the back-face cull block
// Register map, mode codes, controller states and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package bfc_pkg;

	localparam int unsigned VERTEX_DEPTH_DEF = 1024;
	localparam int unsigned COUNT_WIDTH_DEF  = 8;

	localparam int unsigned IDX_W     = 10;
	localparam int unsigned IDX_EXT_W = 17;
	localparam int unsigned FIX_W     = 32;
	localparam int unsigned PROD_W    = 64;
	localparam int unsigned ACC_W     = 66;
	localparam int unsigned FRAC_W    = 16;
	localparam int unsigned UC_W      = 8;
	localparam int unsigned DIR_W     = 2;

	localparam int unsigned APB_AW = 5;
	localparam int unsigned APB_DW = 32;
	localparam int unsigned REG_W  = 3;

	typedef logic [REG_W-1:0] reg_idx_t;
	localparam reg_idx_t REG_CULL_MODE  = 3'd0;
	localparam reg_idx_t REG_PROJECTION = 3'd1;
	localparam reg_idx_t REG_EYE_X      = 3'd2;
	localparam reg_idx_t REG_EYE_Y      = 3'd3;
	localparam reg_idx_t REG_EYE_Z      = 3'd4;

	localparam logic [1:0] CULL_NONE     = 2'd0;
	localparam logic [1:0] CULL_ONE_SIDE = 2'd1;
	localparam logic [1:0] CULL_TWO_SIDE = 2'd2;
	localparam logic [1:0] PROJ_PERSP    = 2'd0;
	localparam logic [1:0] PROJ_PARALLEL = 2'd1;

	localparam logic [DIR_W-1:0] DIR_NONE  = 2'b00;
	localparam logic [DIR_W-1:0] DIR_FRONT = 2'b01;
	localparam logic [DIR_W-1:0] DIR_BACK  = 2'b10;

	typedef struct packed {
		logic [1:0]       cull_mode;
		logic [1:0]       projection;
		logic [FIX_W-1:0] eye_x;
		logic [FIX_W-1:0] eye_y;
		logic [FIX_W-1:0] eye_z;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL_X,
		ST_MUL_Y,
		ST_MUL_Z,
		ST_ACC_Z,
		ST_UPD_A,
		ST_UPD_B,
		ST_UPD_C,
		ST_RD_ISSUE,
		ST_RD_DONE,
		ST_DONE
	} ctl_state_t;

	typedef enum logic [1:0] {
		MUL_X,
		MUL_Y,
		MUL_Z
	} mul_sel_t;

	typedef enum logic [1:0] {
		SLOT_A,
		SLOT_B,
		SLOT_C,
		SLOT_R
	} slot_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_SWEEP,
		WR_UPDATE,
		WR_ERASE
	} wr_op_t;

	typedef struct packed {
		logic     capture;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     acc_add;
		slot_t    rd_slot;
		wr_op_t   wr_op;
		slot_t    wr_slot;
		logic     res_face;
		logic     res_read;
		logic     load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
	} dp_stat_t;

endpackage : bfc_pkg
`default_nettype wire

FILE: src/bfc_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfc_cfg: configuration register file
// APB-style slave holding cull mode, projection and the eye position.
// ----------------------------------------------------------------------------
module bfc_cfg
	import bfc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     wr_en;

	assign reg_idx = paddr[APB_AW-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cull_mode  <= CULL_ONE_SIDE;
			cfg_q.projection <= PROJ_PERSP;
			cfg_q.eye_x      <= '0;
			cfg_q.eye_y      <= '0;
			cfg_q.eye_z      <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_CULL_MODE:  cfg_q.cull_mode  <= pwdata[1:0];
				REG_PROJECTION: cfg_q.projection <= pwdata[1:0];
				REG_EYE_X:      cfg_q.eye_x      <= pwdata;
				REG_EYE_Y:      cfg_q.eye_y      <= pwdata;
				REG_EYE_Z:      cfg_q.eye_z      <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_CULL_MODE:  prdata = APB_DW'(cfg_q.cull_mode);
			REG_PROJECTION: prdata = APB_DW'(cfg_q.projection);
			REG_EYE_X:      prdata = cfg_q.eye_x;
			REG_EYE_Y:      prdata = cfg_q.eye_y;
			REG_EYE_Z:      prdata = cfg_q.eye_z;
			default:        prdata = '0;
		endcase
	end

endmodule : bfc_cfg
`default_nettype wire

FILE: src/bfc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfc_ctrl: sequencing state machine
// Steps the clearing sweep, the dot product, the three vertex updates and the
// read-and-clear, and owns the output valid flag.
// ----------------------------------------------------------------------------
module bfc_ctrl
	import bfc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire logic     action,
	input  wire logic     out_stall,
	input  dp_stat_t      stat,
	output logic          in_stall,
	output logic          out_valid,
	output dp_cmd_t       cmd,
	output ctl_state_t    state
);

	ctl_state_t state_q;
	ctl_state_t state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign state     = state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.wr_op = WR_SWEEP;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = action ? ST_RD_ISSUE : ST_MUL_X;
				end
			end
			ST_MUL_X: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_X;
				state_d     = ST_MUL_Y;
			end
			ST_MUL_Y: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_Y;
				cmd.acc_add = 1'b1;
				state_d     = ST_MUL_Z;
			end
			ST_MUL_Z: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_Z;
				cmd.acc_add = 1'b1;
				state_d     = ST_ACC_Z;
			end
			ST_ACC_Z: begin
				cmd.acc_add = 1'b1;
				cmd.rd_slot = SLOT_A;
				state_d     = ST_UPD_A;
			end
			ST_UPD_A: begin
				cmd.wr_op   = WR_UPDATE;
				cmd.wr_slot = SLOT_A;
				cmd.rd_slot = SLOT_B;
				state_d     = ST_UPD_B;
			end
			ST_UPD_B: begin
				cmd.wr_op   = WR_UPDATE;
				cmd.wr_slot = SLOT_B;
				cmd.rd_slot = SLOT_C;
				state_d     = ST_UPD_C;
			end
			ST_UPD_C: begin
				cmd.wr_op    = WR_UPDATE;
				cmd.wr_slot  = SLOT_C;
				cmd.res_face = 1'b1;
				state_d      = ST_DONE;
			end
			ST_RD_ISSUE: begin
				cmd.rd_slot = SLOT_R;
				state_d     = ST_RD_DONE;
			end
			ST_RD_DONE: begin
				cmd.wr_op    = WR_ERASE;
				cmd.wr_slot  = SLOT_R;
				cmd.res_read = 1'b1;
				state_d      = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule : bfc_ctrl
`default_nettype wire

FILE: src/bfc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfc_dp: back-face cull datapath
// Shared 32x32 multiplier, exact plane accumulator, vertex count and mark
// memory with write-to-read forwarding, and the result and output registers.
// ----------------------------------------------------------------------------
module bfc_dp
	import bfc_pkg::*;
#(
	parameter int unsigned VERTEX_DEPTH = VERTEX_DEPTH_DEF,
	parameter int unsigned COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  cfg_t                         cfg,
	input  dp_cmd_t                      cmd,
	output dp_stat_t                     stat,
	input  wire logic signed [FIX_W-1:0] normal_x,
	input  wire logic signed [FIX_W-1:0] normal_y,
	input  wire logic signed [FIX_W-1:0] normal_z,
	input  wire logic signed [FIX_W-1:0] plane_d,
	input  wire logic [IDX_W-1:0]        vert_a,
	input  wire logic [IDX_W-1:0]        vert_b,
	input  wire logic [IDX_W-1:0]        vert_c,
	input  wire logic [IDX_W-1:0]        read_index,
	output logic                         face_visible,
	output logic                         face_reversed,
	output logic [UC_W-1:0]              use_count,
	output logic                         front_mark,
	output logic                         back_mark
);

	localparam int unsigned AW    = $clog2(VERTEX_DEPTH);
	localparam int unsigned WW    = COUNT_WIDTH + DIR_W;
	localparam int unsigned EXT_W = COUNT_WIDTH + UC_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX   = '1;
	localparam logic [AW-1:0]          LAST_ADDR = AW'(VERTEX_DEPTH - 1);
	localparam logic [IDX_EXT_W-1:0]   DEPTH_EXT = IDX_EXT_W'(VERTEX_DEPTH);

	// operand and index captures
	logic signed [FIX_W-1:0]  nx_q, ny_q, nz_q;
	logic [IDX_W-1:0]         va_q, vb_q, vc_q, ridx_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  d_scaled;

	logic signed [FIX_W-1:0]  mul_a, mul_b;

	// vertex store
	logic [WW-1:0] mem [VERTEX_DEPTH];
	logic [WW-1:0] rd_q;
	logic [WW-1:0] fwd_q;
	logic          fwd_hit_q;
	logic [AW-1:0] clr_addr_q;

	logic [IDX_W-1:0]     rd_idx, wr_idx;
	logic [IDX_EXT_W-1:0] rd_ext, wr_ext;
	logic [AW-1:0]        rd_addr, wr_addr_slot, waddr;
	logic                 wr_in_range;
	logic                 we;
	logic [WW-1:0]        wdata;

	logic [WW-1:0]          cur;
	logic [COUNT_WIDTH-1:0] cur_cnt, inc_cnt;
	logic [DIR_W-1:0]       cur_dir;
	logic [EXT_W-1:0]       cnt_wide;

	logic             culling, away, vis_c, rev_c;
	logic [DIR_W-1:0] face_dir;

	logic            res_visible_q, res_reversed_q, res_front_q, res_back_q;
	logic [UC_W-1:0] res_count_q;
	logic            out_visible_q, out_reversed_q, out_front_q, out_back_q;
	logic [UC_W-1:0] out_count_q;

	function automatic logic [IDX_W-1:0] slot_index(
		input slot_t            s,
		input logic [IDX_W-1:0] a,
		input logic [IDX_W-1:0] b,
		input logic [IDX_W-1:0] c,
		input logic [IDX_W-1:0] r
	);
		logic [IDX_W-1:0] v;
		unique case (s)
			SLOT_A:  v = a;
			SLOT_B:  v = b;
			SLOT_C:  v = c;
			SLOT_R:  v = r;
			default: v = r;
		endcase
		return v;
	endfunction

	// capture; preload minus the scaled offset, or zero if not perspective
	assign d_scaled = ACC_W'(plane_d) <<< FRAC_W;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			nx_q   <= normal_x;
			ny_q   <= normal_y;
			nz_q   <= normal_z;
			va_q   <= vert_a;
			vb_q   <= vert_b;
			vc_q   <= vert_c;
			ridx_q <= read_index;
			acc_q  <= (cfg.projection == PROJ_PERSP) ? -d_scaled : '0;
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + ACC_W'(prod_q);
		end
	end

	always_comb begin
		unique case (cmd.mul_sel)
			MUL_X: begin
				mul_a = nx_q;
				mul_b = signed'(cfg.eye_x);
			end
			MUL_Y: begin
				mul_a = ny_q;
				mul_b = signed'(cfg.eye_y);
			end
			MUL_Z: begin
				mul_a = nz_q;
				mul_b = signed'(cfg.eye_z);
			end
			default: begin
				mul_a = nz_q;
				mul_b = signed'(cfg.eye_z);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
	end

	// face decision, valid once the last product is in
	always_comb begin
		culling  = ((cfg.cull_mode == CULL_ONE_SIDE) || (cfg.cull_mode == CULL_TWO_SIDE))
			&& ((cfg.projection == PROJ_PERSP) || (cfg.projection == PROJ_PARALLEL));
		away     = acc_q[ACC_W-1];
		vis_c    = !(culling && (cfg.cull_mode == CULL_ONE_SIDE) && away);
		rev_c    = culling && (cfg.cull_mode == CULL_TWO_SIDE) && away;
		face_dir = DIR_NONE;
		if (culling && (cfg.cull_mode == CULL_TWO_SIDE)) begin
			face_dir = away ? DIR_BACK : DIR_FRONT;
		end
	end

	// addressing
	assign rd_idx       = slot_index(cmd.rd_slot, va_q, vb_q, vc_q, ridx_q);
	assign wr_idx       = slot_index(cmd.wr_slot, va_q, vb_q, vc_q, ridx_q);
	assign rd_ext       = IDX_EXT_W'(rd_idx);
	assign wr_ext       = IDX_EXT_W'(wr_idx);
	assign rd_addr      = rd_ext[AW-1:0];
	assign wr_addr_slot = wr_ext[AW-1:0];
	assign wr_in_range  = wr_ext < DEPTH_EXT;

	// read data, patched with a same-entry write issued along with the read
	assign cur      = fwd_hit_q ? fwd_q : rd_q;
	assign cur_cnt  = cur[COUNT_WIDTH-1:0];
	assign cur_dir  = cur[WW-1 -: DIR_W];
	assign inc_cnt  = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + COUNT_WIDTH'(1);
	assign cnt_wide = EXT_W'(cur_cnt);

	always_comb begin
		we    = 1'b0;
		waddr = wr_addr_slot;
		wdata = '0;
		unique case (cmd.wr_op)
			WR_NONE: begin
				we = 1'b0;
			end
			WR_SWEEP: begin
				we    = 1'b1;
				waddr = clr_addr_q;
			end
			WR_UPDATE: begin
				we    = vis_c && wr_in_range;
				wdata = {cur_dir | face_dir, inc_cnt};
			end
			WR_ERASE: begin
				we = wr_in_range;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q  <= mem[rd_addr];
		fwd_q <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q  <= 1'b0;
			clr_addr_q <= '0;
		end else begin
			fwd_hit_q <= we && (waddr == rd_addr);
			if (cmd.wr_op == WR_SWEEP) begin
				clr_addr_q <= (clr_addr_q == LAST_ADDR) ? '0 : clr_addr_q + AW'(1);
			end
		end
	end

	assign stat.clr_last = (clr_addr_q == LAST_ADDR);

	// result staging and output register
	always_ff @(posedge clk) begin
		if (cmd.res_face) begin
			res_visible_q  <= vis_c;
			res_reversed_q <= rev_c;
			res_count_q    <= '0;
			res_front_q    <= 1'b0;
			res_back_q     <= 1'b0;
		end else if (cmd.res_read) begin
			res_visible_q  <= 1'b0;
			res_reversed_q <= 1'b0;
			res_count_q    <= wr_in_range ? cnt_wide[UC_W-1:0] : '0;
			res_front_q    <= wr_in_range && cur_dir[0];
			res_back_q     <= wr_in_range && cur_dir[1];
		end
		if (cmd.load_out) begin
			out_visible_q  <= res_visible_q;
			out_reversed_q <= res_reversed_q;
			out_count_q    <= res_count_q;
			out_front_q    <= res_front_q;
			out_back_q     <= res_back_q;
		end
	end

	assign face_visible  = out_visible_q;
	assign face_reversed = out_reversed_q;
	assign use_count     = out_count_q;
	assign front_mark    = out_front_q;
	assign back_mark     = out_back_q;

endmodule : bfc_dp
`default_nettype wire

FILE: src/backface_cull_vertex_refcount.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: a face steps through MUL_X, MUL_Y, MUL_Z, ACC_Z, UPD_A, UPD_B, UPD_C, DONE;
//   a read RD_ISSUE, RD_DONE, DONE. One at a time; a face is paced by the single shared
//   32x32 multiplier (three products) and the three vertex read-modify-writes.
// Reset: registers return to cull_mode 1, projection 0, eye at the origin; then a
//   clearing sweep zeroes the vertex store, with in_stall held high throughout.
// ----------------------------------------------------------------------------
// backface_cull_vertex_refcount: back-face test with vertex use counting
// Decides per triangle whether it faces the configured eye, counts uses of
// the vertices of kept faces and serves read-and-clear requests on them.
// ----------------------------------------------------------------------------
module backface_cull_vertex_refcount
	import bfc_pkg::*;
#(
	parameter int unsigned VERTEX_DEPTH = VERTEX_DEPTH_DEF,
	parameter int unsigned COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// configuration port
	input  wire logic                    psel,
	input  wire logic                    penable,
	input  wire logic                    pwrite,
	input  wire logic [APB_AW-1:0]       paddr,
	input  wire logic [APB_DW-1:0]       pwdata,
	output logic      [APB_DW-1:0]       prdata,
	output logic                         pready,
	// input channel
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic                    action,
	input  wire logic signed [FIX_W-1:0] normal_x,
	input  wire logic signed [FIX_W-1:0] normal_y,
	input  wire logic signed [FIX_W-1:0] normal_z,
	input  wire logic signed [FIX_W-1:0] plane_d,
	input  wire logic [IDX_W-1:0]        vert_a,
	input  wire logic [IDX_W-1:0]        vert_b,
	input  wire logic [IDX_W-1:0]        vert_c,
	input  wire logic [IDX_W-1:0]        read_index,
	// output channel
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic                         face_visible,
	output logic                         face_reversed,
	output logic [UC_W-1:0]              use_count,
	output logic                         front_mark,
	output logic                         back_mark
);

	cfg_t       cfg;
	dp_cmd_t    cmd;
	dp_stat_t   stat;
	ctl_state_t fsm_state;

	// Register file: the user must ensure it is written only while the block is idle,
	// so the datapath may read the fields directly during a transaction; not enforced.
	bfc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Controller: sweep after reset, then one transaction at a time. A face
	// walks three multiplies, the final accumulate, and three vertex
	// read-modify-writes overlapped one entry per cycle; a read fetches and
	// clears one entry. The finished result waits in a staging register until
	// the output register is free.
	bfc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.action    (action),
		.out_stall (out_stall),
		.stat      (stat),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd),
		.state     (fsm_state)
	);

	// Datapath: exact 66-bit signed plane sum, sign decides the facing;
	// counts saturate, marks accumulate by OR.
	bfc_dp #(
		.VERTEX_DEPTH (VERTEX_DEPTH),
		.COUNT_WIDTH  (COUNT_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cmd           (cmd),
		.stat          (stat),
		.normal_x      (normal_x),
		.normal_y      (normal_y),
		.normal_z      (normal_z),
		.plane_d       (plane_d),
		.vert_a        (vert_a),
		.vert_b        (vert_b),
		.vert_c        (vert_c),
		.read_index    (read_index),
		.face_visible  (face_visible),
		.face_reversed (face_reversed),
		.use_count     (use_count),
		.front_mark    (front_mark),
		.back_mark     (back_mark)
	);

`ifndef SYNTHESIS
	// hold off the next transaction while one is in flight
	a_one_in_flight : assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("transaction accepted while previous one in flight");

	// a new result appears only out of the done state
	a_out_from_done : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(fsm_state == ST_DONE))
		else $error("output valid rose outside the done state");

	// accept only from idle, never during the sweep or a transaction
	a_stall_busy : assert property (@(posedge clk) disable iff (!arst_n)
		(fsm_state != ST_IDLE) |-> in_stall)
		else $error("input not stalled while busy");
`endif

endmodule : backface_cull_vertex_refcount
`default_nettype wire

FILE: dv/bfc_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfc_result_checker: result checker for the back-face cull block
// Follows register writes on the configuration port, predicts every accepted
// transaction on the input channel and compares each result, field by field,
// with the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module bfc_result_checker
	import bfc_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    psel,
	input  wire logic                    penable,
	input  wire logic                    pwrite,
	input  wire logic                    pready,
	input  wire logic [APB_AW-1:0]       paddr,
	input  wire logic [APB_DW-1:0]       pwdata,
	input  wire logic                    in_valid,
	input  wire logic                    in_stall,
	input  wire logic                    action,
	input  wire logic signed [FIX_W-1:0] normal_x,
	input  wire logic signed [FIX_W-1:0] normal_y,
	input  wire logic signed [FIX_W-1:0] normal_z,
	input  wire logic signed [FIX_W-1:0] plane_d,
	input  wire logic [IDX_W-1:0]        vert_a,
	input  wire logic [IDX_W-1:0]        vert_b,
	input  wire logic [IDX_W-1:0]        vert_c,
	input  wire logic [IDX_W-1:0]        read_index,
	input  wire logic                    out_valid,
	input  wire logic                    out_stall,
	input  wire logic                    face_visible,
	input  wire logic                    face_reversed,
	input  wire logic [UC_W-1:0]         use_count,
	input  wire logic                    front_mark,
	input  wire logic                    back_mark,
	output int unsigned                  mismatch_count,
	output int unsigned                  outstanding
);

	localparam int unsigned SUM_W = 68;
	localparam logic [UC_W-1:0] COUNT_TOP = UC_W'((1 << COUNT_WIDTH_DEF) - 1);

	typedef struct packed {
		logic            visible;
		logic            reversed;
		logic [UC_W-1:0] count;
		logic            front;
		logic            back;
	} outcome_t;

	logic [1:0]              cur_cull;
	logic [1:0]              cur_proj;
	logic signed [FIX_W-1:0] eye_x_q;
	logic signed [FIX_W-1:0] eye_y_q;
	logic signed [FIX_W-1:0] eye_z_q;
	logic [UC_W-1:0]         use_tally [VERTEX_DEPTH_DEF];
	logic [DIR_W-1:0]        side_seen [VERTEX_DEPTH_DEF];
	outcome_t                due_outcomes [$];
	int unsigned             misses = 0;

	task automatic report_mismatch(input string what);
		misses++;
		$display("%0t ns  checker: %s", $time, what);
	endtask

	// exact sign of (normal . eye) - offset; operands in 16.16, sum with 32 fraction bits
	function automatic logic points_away(input logic signed [FIX_W-1:0] nx, ny, nz, off);
		logic signed [SUM_W-1:0] acc;
		acc = nx * eye_x_q + ny * eye_y_q + nz * eye_z_q - (off <<< FRAC_W);
		return acc[SUM_W-1];
	endfunction

	function automatic void bump_vertex(input logic [IDX_W-1:0] idx, input logic [DIR_W-1:0] dir);
		if (use_tally[idx] != COUNT_TOP)
			use_tally[idx] = use_tally[idx] + 1'b1;
		side_seen[idx] = side_seen[idx] | dir;
	endfunction

	function automatic outcome_t cull_and_count();
		outcome_t         o;
		logic             culling;
		logic             away;
		logic             keep;
		logic [DIR_W-1:0] dir;
		o = '0;
		if (action) begin
			o.count = use_tally[read_index];
			o.front = side_seen[read_index][0];
			o.back  = side_seen[read_index][1];
			use_tally[read_index] = '0;
			side_seen[read_index] = DIR_NONE;
			return o;
		end
		culling = (cur_cull == CULL_ONE_SIDE || cur_cull == CULL_TWO_SIDE) &&
			(cur_proj == PROJ_PERSP || cur_proj == PROJ_PARALLEL);
		keep = 1'b1;
		dir  = DIR_NONE;
		if (culling) begin
			away = points_away(normal_x, normal_y, normal_z,
				(cur_proj == PROJ_PERSP) ? plane_d : '0);
			if (cur_cull == CULL_ONE_SIDE) begin
				keep = !away;
			end else begin
				o.reversed = away;
				dir = away ? DIR_BACK : DIR_FRONT;
			end
		end
		if (keep) begin
			bump_vertex(vert_a, dir);
			bump_vertex(vert_b, dir);
			bump_vertex(vert_c, dir);
		end
		o.visible = keep;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t got;
		outcome_t want;
		if (!arst_n) begin
			cur_cull = CULL_ONE_SIDE;
			cur_proj = PROJ_PERSP;
			eye_x_q  = '0;
			eye_y_q  = '0;
			eye_z_q  = '0;
			for (int i = 0; i < VERTEX_DEPTH_DEF; i++) begin
				use_tally[i] = '0;
				side_seen[i] = DIR_NONE;
			end
			due_outcomes.delete();
			mismatch_count <= misses;
			outstanding    <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[APB_AW-1:2])
					REG_CULL_MODE:  cur_cull = pwdata[1:0];
					REG_PROJECTION: cur_proj = pwdata[1:0];
					REG_EYE_X:      eye_x_q  = pwdata;
					REG_EYE_Y:      eye_y_q  = pwdata;
					REG_EYE_Z:      eye_z_q  = pwdata;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				got = '{face_visible, face_reversed, use_count, front_mark, back_mark};
				if (due_outcomes.size() == 0) begin
					report_mismatch($sformatf("result %h with no transaction outstanding", got));
				end else begin
					want = due_outcomes.pop_front();
					if (got.visible !== want.visible)
						report_mismatch($sformatf("face_visible got %b want %b",
							got.visible, want.visible));
					if (got.reversed !== want.reversed)
						report_mismatch($sformatf("face_reversed got %b want %b",
							got.reversed, want.reversed));
					if (got.count !== want.count)
						report_mismatch($sformatf("use_count got %0d want %0d",
							got.count, want.count));
					if (got.front !== want.front)
						report_mismatch($sformatf("front_mark got %b want %b",
							got.front, want.front));
					if (got.back !== want.back)
						report_mismatch($sformatf("back_mark got %b want %b",
							got.back, want.back));
				end
			end
			if (in_valid && !in_stall)
				due_outcomes.push_back(cull_and_count());
			mismatch_count <= misses;
			outstanding    <= due_outcomes.size();
		end
	end

endmodule : bfc_result_checker

FILE: dv/backface_cull_vertex_refcount_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// backface_cull_vertex_refcount_test: stimulus and verdict for the cull block
// Runs a short directed sequence over the face decision corners, then random
// configuration phases with face and read-and-clear transactions, random
// gaps on the sender and random stalls on the receiver. The checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module backface_cull_vertex_refcount_test;
	import bfc_pkg::*;

	localparam int unsigned CLK_HALF     = 4;
	localparam int unsigned RESET_CYCLES = 11;
	localparam int unsigned RANDOM_ITEMS = 1550;
	localparam int unsigned SAT_FACES    = 90;
	localparam int unsigned HOLD_AFTER   = 300;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned CYCLE_LIMIT  = 1_000_000;

	localparam logic [FIX_W-1:0] FIX_MIN  = 32'h8000_0000;
	localparam logic [FIX_W-1:0] FIX_MAX  = 32'h7FFF_FFFF;
	localparam logic [FIX_W-1:0] FIX_ONE  = 32'h0001_0000;

	// codes the package leaves unnamed; all three behave as no culling
	localparam logic [1:0] CULL_UNUSED = 2'd3;
	localparam logic [1:0] PROJ_OTHER  = 2'd2;
	localparam logic [1:0] PROJ_UNUSED = 2'd3;

	typedef struct {
		logic             action;
		logic [FIX_W-1:0] nx;
		logic [FIX_W-1:0] ny;
		logic [FIX_W-1:0] nz;
		logic [FIX_W-1:0] d;
		logic [IDX_W-1:0] va;
		logic [IDX_W-1:0] vb;
		logic [IDX_W-1:0] vc;
		logic [IDX_W-1:0] ri;
	} cull_xact_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [APB_AW-1:0]       paddr;
	logic [APB_DW-1:0]       pwdata;
	logic [APB_DW-1:0]       prdata;
	logic                    pready;
	logic                    in_valid;
	logic                    in_stall;
	logic                    action;
	logic signed [FIX_W-1:0] normal_x;
	logic signed [FIX_W-1:0] normal_y;
	logic signed [FIX_W-1:0] normal_z;
	logic signed [FIX_W-1:0] plane_d;
	logic [IDX_W-1:0]        vert_a;
	logic [IDX_W-1:0]        vert_b;
	logic [IDX_W-1:0]        vert_c;
	logic [IDX_W-1:0]        read_index;
	logic                    out_valid;
	logic                    out_stall;
	logic                    face_visible;
	logic                    face_reversed;
	logic [UC_W-1:0]         use_count;
	logic                    front_mark;
	logic                    back_mark;
	int unsigned             mismatch_count;
	int unsigned             outstanding;

	// transactions accepted so far; the receiver uses it to time its long hold
	int unsigned             sent_count = 0;
	// transactions left in the current gap-free burst
	int unsigned             burst_left = 0;

	always #(CLK_HALF) clk = ~clk;

	backface_cull_vertex_refcount dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (action),
		.normal_x      (normal_x),
		.normal_y      (normal_y),
		.normal_z      (normal_z),
		.plane_d       (plane_d),
		.vert_a        (vert_a),
		.vert_b        (vert_b),
		.vert_c        (vert_c),
		.read_index    (read_index),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.face_visible  (face_visible),
		.face_reversed (face_reversed),
		.use_count     (use_count),
		.front_mark    (front_mark),
		.back_mark     (back_mark)
	);

	bfc_result_checker watch (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.action         (action),
		.normal_x       (normal_x),
		.normal_y       (normal_y),
		.normal_z       (normal_z),
		.plane_d        (plane_d),
		.vert_a         (vert_a),
		.vert_b         (vert_b),
		.vert_c         (vert_c),
		.read_index     (read_index),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.face_visible   (face_visible),
		.face_reversed  (face_reversed),
		.use_count      (use_count),
		.front_mark     (front_mark),
		.back_mark      (back_mark),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	// Fixed-point value with weight on the corners: both extremes, zero and
	// small magnitudes near zero, where the compare against the offset matters.
	function automatic logic [FIX_W-1:0] rand_fix();
		case ($urandom_range(0, 9))
			0: return FIX_MIN;
			1: return FIX_MAX;
			2: return '0;
			3: return 32'h0003_0000 - 32'($urandom_range(0, 32'h0006_0000));
			default: return $urandom();
		endcase
	endfunction

	// Mostly a small pool so counts build up and reads find marks; the full
	// range and both end indices keep every index bit moving.
	function automatic logic [IDX_W-1:0] rand_vert();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return IDX_W'($urandom_range(0, 15));
			6: return '1;
			7: return '0;
			default: return IDX_W'($urandom_range(0, 1023));
		endcase
	endfunction

	// Sender gap: mostly none or short, a few long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offer one transaction and hold it until the block takes it. Called at a
	// rising edge; returns at the edge of acceptance with valid still high so
	// that a back-to-back transaction needs only one assignment to in_valid.
	task automatic offer(input cull_xact_t x);
		int gap;
		if (burst_left > 0) begin
			gap = 0;
			burst_left--;
		end else begin
			gap = pick_gap();
			if ($urandom_range(0, 29) == 0)
				burst_left = $urandom_range(20, 60);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		action     <= x.action;
		normal_x   <= x.nx;
		normal_y   <= x.ny;
		normal_z   <= x.nz;
		plane_d    <= x.d;
		vert_a     <= x.va;
		vert_b     <= x.vb;
		vert_c     <= x.vc;
		read_index <= x.ri;
		do @(posedge clk); while (in_stall);
		sent_count++;
	endtask

	// Face transaction; the unused read index is random so it toggles too.
	task automatic face_xact(input logic [FIX_W-1:0] nx, ny, nz, d,
		input logic [IDX_W-1:0] va, vb, vc);
		cull_xact_t x;
		x = '{1'b0, nx, ny, nz, d, va, vb, vc, IDX_W'($urandom())};
		offer(x);
	endtask

	// Read-and-clear transaction; the face fields are random and ignored.
	task automatic read_xact(input logic [IDX_W-1:0] idx);
		cull_xact_t x;
		x = '{1'b1, $urandom(), $urandom(), $urandom(), $urandom(),
			IDX_W'($urandom()), IDX_W'($urandom()), IDX_W'($urandom()), idx};
		offer(x);
	endtask

	// One write: setup cycle, then access cycle; the register takes the
	// value at the edge where psel and penable are both high.
	task automatic write_reg(input reg_idx_t idx, input logic [APB_DW-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Drop valid, let every outstanding result drain, then rewrite all five
	// registers. Step past the current edge first so the checker has counted
	// the transaction accepted at that edge.
	task automatic set_regs(input logic [1:0] cm, pj, input logic [FIX_W-1:0] ex, ey, ez);
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		write_reg(REG_CULL_MODE, APB_DW'(cm));
		write_reg(REG_PROJECTION, APB_DW'(pj));
		write_reg(REG_EYE_X, ex);
		write_reg(REG_EYE_Y, ey);
		write_reg(REG_EYE_Z, ez);
	endtask

	// Receiver: random stall runs, with stall-free stretches, plus one long
	// hold once traffic is flowing so the block backs up into its input.
	initial begin : receiver
		int   r;
		int   run;
		logic stall_v;
		logic hold_done;
		hold_done = 1'b0;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (!hold_done && sent_count >= HOLD_AFTER) begin
				@(posedge clk) out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 10) begin
					stall_v = 1'b0;
					run = $urandom_range(20, 80);
				end else if (r < 15) begin
					stall_v = 1'b1;
					run = $urandom_range(10, 40);
				end else begin
					stall_v = ($urandom_range(0, 2) == 0);
					run = $urandom_range(0, 3);
				end
				@(posedge clk) out_stall <= stall_v;
				repeat (run) @(posedge clk);
			end
		end
	end

	// Cycle limit: the run has hung if it gets this far.
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin : stimulus
		int unsigned      random_done;
		int unsigned      phase;
		int unsigned      left;
		int               r;
		logic             eye_unit;
		logic [1:0]       cm;
		logic [1:0]       pj;
		logic [FIX_W-1:0] ex;
		logic [FIX_W-1:0] ey;
		logic [FIX_W-1:0] ez;
		logic [FIX_W-1:0] nx;
		logic [FIX_W-1:0] d;
		logic [IDX_W-1:0] hot;

		arst_n     <= 1'b0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		in_valid   <= 1'b0;
		action     <= 1'b0;
		normal_x   <= '0;
		normal_y   <= '0;
		normal_z   <= '0;
		plane_d    <= '0;
		vert_a     <= '0;
		vert_b     <= '0;
		vert_c     <= '0;
		read_index <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: one-sided, perspective, eye at the origin, so the
		// dot product is zero and the offset alone decides. A positive
		// offset culls; equality keeps the face.
		face_xact($urandom(), $urandom(), $urandom(), FIX_MAX, 10'd0, 10'd1, 10'd2);
		face_xact($urandom(), $urandom(), $urandom(), FIX_MIN, '1, '1, '1);
		face_xact($urandom(), $urandom(), $urandom(), '0, 10'd0, 10'd0, 10'd5);
		read_xact('1);
		read_xact(10'd0);

		// Two-sided with a unit eye on x: the dot product equals normal_x,
		// so an offset equal to it faces the eye and one above points away.
		set_regs(CULL_TWO_SIDE, PROJ_PERSP, FIX_ONE, '0, '0);
		face_xact(32'h0005_0000, $urandom(), $urandom(), 32'h0005_0000, 10'd10, 10'd11, 10'd12);
		face_xact(32'h0005_0000, $urandom(), $urandom(), 32'h0005_0001, 10'd10, 10'd11, 10'd12);
		read_xact(10'd10);
		read_xact(10'd10);

		// Parallel with extreme eye and normals: the largest positive and
		// negative sums; the offset must be ignored.
		set_regs(CULL_TWO_SIDE, PROJ_PARALLEL, FIX_MIN, FIX_MIN, FIX_MIN);
		face_xact(FIX_MIN, FIX_MIN, FIX_MIN, FIX_MAX, 10'd20, 10'd21, 10'd22);
		face_xact(FIX_MAX, FIX_MAX, FIX_MAX, FIX_MIN, 10'd20, 10'd20, 10'd20);
		read_xact(10'd20);
		read_xact(10'd21);

		set_regs(CULL_ONE_SIDE, PROJ_PARALLEL, FIX_MAX, FIX_MAX, FIX_MAX);
		face_xact(FIX_MAX, FIX_MAX, FIX_MAX, '0, 10'd30, 10'd31, 10'd32);
		face_xact(FIX_MIN, FIX_MIN, FIX_MIN, '0, 10'd30, 10'd31, 10'd32);

		// Unused cull mode, no culling and the other projections: nothing is culled,
		// nothing reversed and no marks set.
		set_regs(CULL_UNUSED, PROJ_PERSP, FIX_MAX, FIX_MIN, FIX_MAX);
		face_xact(FIX_MIN, FIX_MIN, FIX_MIN, FIX_MAX, 10'd30, 10'd30, 10'd30);
		read_xact(10'd30);
		set_regs(CULL_TWO_SIDE, PROJ_OTHER, FIX_MAX, FIX_MAX, FIX_MAX);
		face_xact(FIX_MIN, FIX_MIN, FIX_MIN, '0, 10'd40, 10'd41, 10'd42);
		set_regs(CULL_ONE_SIDE, PROJ_UNUSED, FIX_MAX, FIX_MAX, FIX_MAX);
		face_xact(FIX_MIN, FIX_MIN, FIX_MIN, FIX_MAX, 10'd40, 10'd41, 10'd42);
		read_xact(10'd40);
		set_regs(CULL_NONE, PROJ_PARALLEL, FIX_MIN, FIX_MIN, FIX_MIN);
		face_xact(FIX_MAX, FIX_MAX, FIX_MAX, '0, 10'd50, 10'd51, 10'd52);
		read_xact(10'd52);

		// Random phases: new settings, then a run of faces and reads. The
		// second phase hammers one vertex past the count's ceiling first.
		random_done = 0;
		phase = 0;
		while (random_done < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: cm = CULL_NONE;
				1: cm = CULL_UNUSED;
				2, 3, 4, 5: cm = CULL_ONE_SIDE;
				default: cm = CULL_TWO_SIDE;
			endcase
			case ($urandom_range(0, 9))
				0: pj = PROJ_OTHER;
				1: pj = PROJ_UNUSED;
				2, 3, 4, 5: pj = PROJ_PERSP;
				default: pj = PROJ_PARALLEL;
			endcase
			eye_unit = 1'b0;
			case ($urandom_range(0, 5))
				0: begin
					ex = FIX_ONE;
					ey = '0;
					ez = '0;
					eye_unit = 1'b1;
				end
				1: begin
					ex = FIX_MIN;
					ey = FIX_MIN;
					ez = FIX_MIN;
				end
				2: begin
					ex = FIX_MAX;
					ey = FIX_MAX;
					ez = FIX_MAX;
				end
				default: begin
					ex = rand_fix();
					ey = rand_fix();
					ez = rand_fix();
				end
			endcase
			if (phase == 1)
				cm = CULL_NONE;
			set_regs(cm, pj, ex, ey, ez);

			if (phase == 1) begin
				hot = IDX_W'($urandom());
				repeat (SAT_FACES)
					face_xact(rand_fix(), rand_fix(), rand_fix(), rand_fix(), hot, hot, hot);
				read_xact(hot);
				random_done += SAT_FACES + 1;
			end

			left = $urandom_range(60, 140);
			repeat (left) begin
				r = $urandom_range(0, 99);
				if (r < 22) begin
					read_xact(rand_vert());
				end else if (r < 27) begin
					read_xact(IDX_W'($urandom()));
				end else begin
					nx = rand_fix();
					d  = rand_fix();
					// with a unit eye, land the offset on or next to the dot product
					if (eye_unit && $urandom_range(0, 2) == 0)
						d = nx - 32'd1 + 32'($urandom_range(0, 2));
					face_xact(nx, rand_fix(), rand_fix(), d,
						rand_vert(), rand_vert(), rand_vert());
				end
				random_done++;
			end
			phase++;
		end

		// Drain: drop valid, wait out every result, then a short quiet tail
		// to catch anything extra the block might still emit.
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule : backface_cull_vertex_refcount_test
